@@ rtl/oxs_pkg.sv @@
// ----------------------------------------------------------------------------
// oxs_pkg
// Shared types and constants of the order crossover block: request, result
// and queued job formats, operation codes and sizes.
// ----------------------------------------------------------------------------
package oxs_pkg;

	localparam int SPAN               = 16;
	localparam int POS_W              = 4;
	localparam int CITY_W             = 4;
	localparam int CNT_W              = 5;
	localparam int MAX_CITIES_DEFAULT = 16;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [CNT_W-1:0] CITY_COUNT_RESET = 5'd10;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	typedef enum logic [1:0] {
		OP_SKIP,
		OP_LOAD,
		OP_RUN
	} op_t;

	typedef struct packed {
		logic              cmd;
		logic [POS_W-1:0]  position;
		logic [CITY_W-1:0] gene_first;
		logic [CITY_W-1:0] gene_second;
		logic [POS_W-1:0]  cut_start;
		logic [POS_W-1:0]  cut_end;
		logic              do_swap;
		logic [POS_W-1:0]  swap_first;
		logic [POS_W-1:0]  swap_second;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0]  child_position;
		logic [CITY_W-1:0] child_city;
		logic              filled;
		logic              last;
	} rsp_t;

	typedef struct packed {
		op_t               op;
		logic [POS_W-1:0]  position;
		logic [CITY_W-1:0] gene_first;
		logic [CITY_W-1:0] gene_second;
		logic [POS_W-1:0]  seg_start;
		logic [POS_W-1:0]  seg_end;
		logic [CNT_W-1:0]  count;
		logic              swap_ok;
		logic [POS_W-1:0]  swap_first;
		logic [POS_W-1:0]  swap_second;
	} job_t;

endpackage

@@ rtl/oxs_front.sv @@
// ----------------------------------------------------------------------------
// oxs_front
// Holds the city count register, classifies each request as load, run or
// dropped load, clamps cut points to the count and drops out-of-range swaps.
// ----------------------------------------------------------------------------
module oxs_front
	import oxs_pkg::*;
#(
	parameter int MAX_CITIES = MAX_CITIES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic [CNT_W-1:0] cfg_write_data,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req_item,
	output logic             job_valid,
	input  logic             job_ready,
	output job_t             job
);

	localparam int LIMIT = (MAX_CITIES < SPAN) ? MAX_CITIES : SPAN;

	logic [CNT_W-1:0] city_count_q;
	logic [CNT_W-1:0] count;
	logic [POS_W-1:0] count_m1;
	logic [POS_W-1:0] seg_start;
	logic [POS_W-1:0] end_raised;
	logic [POS_W-1:0] seg_end;
	logic             swap_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= CITY_COUNT_RESET;
		end else if (cfg_write_en) begin
			city_count_q <= cfg_write_data;
		end
	end

	always_comb begin
		if (city_count_q < CNT_W'(2)) begin
			count = CNT_W'(2);
		end else if (city_count_q > CNT_W'(LIMIT)) begin
			count = CNT_W'(LIMIT);
		end else begin
			count = city_count_q;
		end
		count_m1   = POS_W'(count - CNT_W'(1));
		seg_start  = (req_item.cut_start > count_m1) ? count_m1 : req_item.cut_start;
		end_raised = (req_item.cut_end < seg_start) ? seg_start : req_item.cut_end;
		seg_end    = (end_raised > count_m1) ? count_m1 : end_raised;
		swap_ok    = req_item.do_swap
			&& ({1'b0, req_item.swap_first} < count)
			&& ({1'b0, req_item.swap_second} < count);
	end

	always_comb begin
		job = '0;
		if (req_item.cmd == CMD_RUN) begin
			job.op = OP_RUN;
		end else if (int'(req_item.position) < MAX_CITIES) begin
			job.op = OP_LOAD;
		end else begin
			job.op = OP_SKIP;
		end
		job.position    = req_item.position;
		job.gene_first  = req_item.gene_first;
		job.gene_second = req_item.gene_second;
		job.seg_start   = seg_start;
		job.seg_end     = seg_end;
		job.count       = count;
		job.swap_ok     = swap_ok;
		job.swap_first  = req_item.swap_first;
		job.swap_second = req_item.swap_second;
	end

	assign job_valid = req_valid;
	assign req_ready = job_ready;

endmodule

@@ rtl/oxs_queue.sv @@
// ----------------------------------------------------------------------------
// oxs_queue
// Short first-in first-out queue of classified jobs between the front and
// the back end.
// ----------------------------------------------------------------------------
module oxs_queue
	import oxs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_job,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_job
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	job_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != CNT_QW'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_QW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_QW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ rtl/oxs_back.sv @@
// ----------------------------------------------------------------------------
// oxs_back
// Executes queued jobs: writes parent stores on loads; on runs copies the
// segment, scans the second parent, then emits the child with the swap
// applied as a read remap.
// ----------------------------------------------------------------------------
module oxs_back
	import oxs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  job_t job,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_item
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	state_t            state_q;
	logic [POS_W-1:0]  idx_q;
	logic [CNT_W-1:0]  fill_q;
	logic [POS_W-1:0]  k_q;
	logic [POS_W-1:0]  start_q;
	logic [POS_W-1:0]  end_q;
	logic [CNT_W-1:0]  n_q;
	logic              swap_ok_q;
	logic [POS_W-1:0]  swap_a_q;
	logic [POS_W-1:0]  swap_b_q;
	logic [SPAN-1:0]   filled_q;
	logic [SPAN-1:0]   seg_q;
	logic              vld_s1;
	logic              copy_s1;
	logic [POS_W-1:0]  idx_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [CITY_W-1:0] first_mem [SPAN];
	logic [CITY_W-1:0] second_mem [SPAN];
	logic [CITY_W-1:0] child_mem [SPAN];
	logic [CITY_W-1:0] first_rd_q;
	logic [CITY_W-1:0] second_rd_q;
	logic [CITY_W-1:0] child_rd_q;

	logic              par_we;
	logic [POS_W-1:0]  n_m1;
	logic [CNT_W-1:0]  fill_eff;
	logic              scan_hit;
	logic              cwr_en;
	logic [POS_W-1:0]  cwr_addr;
	logic [CITY_W-1:0] cwr_data;
	logic [POS_W-1:0]  k_src;
	logic              crd_en;
	logic              load_out;

	assign job_ready = (state_q == ST_IDLE);
	assign par_we    = job_ready && job_valid && (job.op == OP_LOAD);
	assign n_m1      = POS_W'(n_q - CNT_W'(1));

	// the fill pointer jumps over the segment when it reaches it
	always_comb begin
		fill_eff = (fill_q == {1'b0, start_q}) ? ({1'b0, end_q} + CNT_W'(1)) : fill_q;
		scan_hit = vld_s1 && !copy_s1 && !seg_q[second_rd_q] && (fill_eff < n_q);
		cwr_en   = (vld_s1 && copy_s1) || scan_hit;
		cwr_addr = copy_s1 ? idx_s1 : fill_eff[POS_W-1:0];
		cwr_data = copy_s1 ? first_rd_q : second_rd_q;
	end

	// swap mutation applied on the read side
	always_comb begin
		if (swap_ok_q && (k_q == swap_a_q)) begin
			k_src = swap_b_q;
		end else if (swap_ok_q && (k_q == swap_b_q)) begin
			k_src = swap_a_q;
		end else begin
			k_src = k_q;
		end
		crd_en   = (state_q == ST_EMIT_RD);
		load_out = (state_q == ST_EMIT_WR) && (!rsp_valid_q || rsp_ready);
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			first_mem[job.position]  <= job.gene_first;
			second_mem[job.position] <= job.gene_second;
		end
		first_rd_q  <= first_mem[idx_q];
		second_rd_q <= second_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cwr_en) begin
			child_mem[cwr_addr] <= cwr_data;
		end
		if (crd_en) begin
			child_rd_q <= child_mem[k_src];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			fill_q      <= '0;
			k_q         <= '0;
			start_q     <= '0;
			end_q       <= '0;
			n_q         <= CNT_W'(2);
			swap_ok_q   <= 1'b0;
			swap_a_q    <= '0;
			swap_b_q    <= '0;
			filled_q    <= '0;
			seg_q       <= '0;
			vld_s1      <= 1'b0;
			copy_s1     <= 1'b0;
			idx_s1      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			vld_s1  <= (state_q == ST_COPY) || (state_q == ST_SCAN);
			copy_s1 <= (state_q == ST_COPY);
			idx_s1  <= idx_q;

			if (cwr_en) begin
				filled_q[cwr_addr] <= 1'b1;
			end
			if (vld_s1 && copy_s1) begin
				seg_q[first_rd_q] <= 1'b1;
			end
			if (scan_hit) begin
				fill_q <= fill_eff + CNT_W'(1);
			end

			if (load_out) begin
				rsp_valid_q          <= 1'b1;
				rsp_q.child_position <= k_q;
				rsp_q.child_city     <= filled_q[k_src] ? child_rd_q : '0;
				rsp_q.filled         <= filled_q[k_src];
				rsp_q.last           <= (k_q == n_m1);
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (job_valid && (job.op == OP_RUN)) begin
						start_q   <= job.seg_start;
						end_q     <= job.seg_end;
						n_q       <= job.count;
						swap_ok_q <= job.swap_ok;
						swap_a_q  <= job.swap_first;
						swap_b_q  <= job.swap_second;
						filled_q  <= '0;
						seg_q     <= '0;
						fill_q    <= '0;
						idx_q     <= job.seg_start;
						state_q   <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (idx_q == end_q) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						idx_q <= idx_q + POS_W'(1);
					end
				end
				ST_SCAN: begin
					if (idx_q == n_m1) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + POS_W'(1);
					end
				end
				ST_DRAIN: begin
					k_q     <= '0;
					state_q <= ST_EMIT_RD;
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (load_out) begin
						if (k_q == n_m1) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + POS_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

`ifndef SYNTHESIS
	a_child_write_in_tour: assert property (@(posedge clk) disable iff (!arst_n)
		cwr_en |-> ({1'b0, cwr_addr} < n_q))
		else $error("child write beyond the tour");

	a_scan_skips_segment: assert property (@(posedge clk) disable iff (!arst_n)
		scan_hit |-> ((cwr_addr < start_q) || (cwr_addr > end_q)))
		else $error("scan placed a city inside the segment");

	a_s1_follows_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ($past(state_q) == ST_COPY || $past(state_q) == ST_SCAN))
		else $error("read pipeline active outside copy or scan");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (k_q == n_m1)) |=> (state_q == ST_IDLE) && rsp_valid_q && rsp_q.last)
		else $error("final gene did not end the run");
`endif

endmodule

@@ rtl/order_crossover_with_swap.sv @@
// ----------------------------------------------------------------------------
// order_crossover_with_swap
// Order crossover of two stored parent tours with an optional swap mutation.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are taken at once while it has room.
// A load writes the parent stores in the back end. A run with count n copies
// the segment and scans the second parent (one parent store read per cycle),
// then emits each gene as one registered read of the child store followed by
// a transfer into the output register, which waits while the output is held.
// The back end takes a new job only once the previous run has finished. A run
// emits n results in position order, the final one marked last.
module order_crossover_with_swap
	import oxs_pkg::*;
#(
	parameter int MAX_CITIES = MAX_CITIES_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic [CNT_W-1:0] cfg_write_data,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req_item,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp_item
);

	logic front_valid;
	logic front_ready;
	job_t front_job;
	logic back_valid;
	logic back_ready;
	job_t back_job;

	oxs_front #(
		.MAX_CITIES(MAX_CITIES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req_item      (req_item),
		.job_valid     (front_valid),
		.job_ready     (front_ready),
		.job           (front_job)
	);

	oxs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_job  (front_job),
		.pop_valid (back_valid),
		.pop_ready (back_ready),
		.pop_job   (back_job)
	);

	oxs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(back_valid),
		.job_ready(back_ready),
		.job      (back_job),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item (rsp_item)
	);

endmodule
